// ----- hdl/down_counter_millisecond_clock_top_macros.svh -----
// ============================================================================
// Assertion macros for the millisecond clock
// Shared concurrent assertion shapes used by the controller and datapath.
// ============================================================================
`ifndef DOWN_COUNTER_MILLISECOND_CLOCK_TOP_MACROS_SVH
`define DOWN_COUNTER_MILLISECOND_CLOCK_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define DCMC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define DCMC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dcmc_pkg.sv -----
// ============================================================================
// Millisecond clock package
// Widths, constants, controller states and the control/status bundles.
// ============================================================================
`default_nettype none

package dcmc_pkg;

    // Field and state widths.
    localparam int COUNTER_BITS = 24;
    localparam int CPU_W        = 8;
    localparam int MS_W         = 32;
    localparam int US_W         = 10;
    localparam int ELAP_W       = COUNTER_BITS + 1;
    localparam int US_SUM_W     = ELAP_W + 1;
    localparam int DIV_CNT_W    = $clog2(ELAP_W);
    localparam int MS_INC_W     = 17;

    // Microseconds per millisecond and its reciprocal, scaled by 2^RECIP_SHIFT.
    // ceil(2^36 / 1000) is exact for every dividend below 2^26.
    localparam int US_PER_MS    = 1000;
    localparam int RECIP_SHIFT  = 36;
    localparam int RECIP_W      = 27;
    localparam int PROD_W       = US_SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(68719477);
    localparam logic [US_W-1:0]    US_PER_MS_V = US_W'(US_PER_MS);

    // Register reset value.
    localparam logic [CPU_W-1:0] CPU_RESET = CPU_W'(48);

    // Command codes.
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_UPD,
        S_OUT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic start;
        logic load_div;
        logic div_step;
        logic mul;
        logic upd;
        logic out_load;
    } t_ctrl_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic running;
        logic div_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hdl/dcmc_in_if.sv -----
// ============================================================================
// Input channel
// Valid/ready channel carrying a command and a down counter sample.
// ============================================================================
`default_nettype none

interface dcmc_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [dcmc_pkg::COUNTER_BITS-1:0] counter_sample;

    modport source (output valid, output cmd, output counter_sample, input ready);
    modport sink   (input valid, input cmd, input counter_sample, output ready);
endinterface

`default_nettype wire

// ----- hdl/dcmc_out_if.sv -----
// ============================================================================
// Output channel
// Valid/ready channel carrying the millisecond count.
// ============================================================================
`default_nettype none

interface dcmc_out_if;
    logic                     valid;
    logic                     ready;
    logic [dcmc_pkg::MS_W-1:0] millis;

    modport source (output valid, output millis, input ready);
    modport sink   (input valid, input millis, output ready);
endinterface

`default_nettype wire

// ----- hdl/dcmc_ctrl.sv -----
// ============================================================================
// Millisecond clock controller
// Sequences a running sample through divide, multiply, update and result hand-off; other items go straight to hand-off.
// ============================================================================
`default_nettype none

`include "down_counter_millisecond_clock_top_macros.svh"

module dcmc_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_cmd,
    output logic                 o_in_ready,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    input  dcmc_pkg::t_dp_status i_status,
    output dcmc_pkg::t_ctrl_cmd  o_cmd
);

    dcmc_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    // The result register may be reloaded once it is empty or being taken.
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcmc_pkg::S_IDLE: begin
                if (i_in_valid && i_in_cmd == dcmc_pkg::CMD_SAMPLE && i_status.running) begin
                    n_state = dcmc_pkg::S_DIV;
                end else if (i_in_valid) begin
                    n_state = dcmc_pkg::S_OUT;
                end
            end
            dcmc_pkg::S_DIV: begin
                if (i_status.div_last) begin
                    n_state = dcmc_pkg::S_MUL;
                end
            end
            dcmc_pkg::S_MUL: begin
                n_state = dcmc_pkg::S_UPD;
            end
            dcmc_pkg::S_UPD: begin
                n_state = dcmc_pkg::S_OUT;
            end
            dcmc_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = dcmc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dcmc_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dcmc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_cmd == dcmc_pkg::CMD_SAMPLE && i_status.running) begin
                    o_cmd.load_div = 1'b1;
                end else if (i_in_valid && i_in_cmd == dcmc_pkg::CMD_START
                             && !i_status.running) begin
                    o_cmd.start = 1'b1;
                end
            end
            dcmc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            dcmc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            dcmc_pkg::S_UPD: begin
                o_cmd.upd = 1'b1;
            end
            dcmc_pkg::S_OUT: begin
                o_cmd.out_load = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Result valid flag: set on load, cleared when the item is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcmc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A waiting result is never overwritten.
    `DCMC_ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, w_out_free, "result overwritten")
    // The result appears only after the hand-off state.
    `DCMC_ASSERT_IMPLIES(a_valid_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == dcmc_pkg::S_OUT, "result valid outside hand-off")
    // The multiply step always follows the last divide step.
    `DCMC_ASSERT_IMPLIES(a_mul_after_div, i_clk, i_rst_n, r_state == dcmc_pkg::S_MUL, $past(r_state) == dcmc_pkg::S_DIV && $past(i_status.div_last), "multiply without finished divide")

endmodule

`default_nettype wire

// ----- hdl/dcmc_dp.sv -----
// ============================================================================
// Millisecond clock datapath
// Time state, bit-serial cycle divider, millisecond carry and result register.
// ============================================================================
`default_nettype none

`include "down_counter_millisecond_clock_top_macros.svh"

module dcmc_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [dcmc_pkg::CPU_W-1:0]          i_cfg_wdata,
    input  wire [dcmc_pkg::COUNTER_BITS-1:0]   i_counter_sample,
    input  dcmc_pkg::t_ctrl_cmd                i_cmd,
    output dcmc_pkg::t_dp_status               o_status,
    output logic [dcmc_pkg::MS_W-1:0]          o_millis
);

    // Time state.
    logic [dcmc_pkg::MS_W-1:0]         r_ms_count;
    logic [dcmc_pkg::US_W-1:0]         r_us_rem;
    logic [dcmc_pkg::CPU_W-1:0]        r_cyc_rem;
    logic [dcmc_pkg::COUNTER_BITS-1:0] r_last;
    logic                              r_running;
    logic [dcmc_pkg::CPU_W-1:0]        r_cycles_per_us;

    // Divider and carry working registers.
    logic [dcmc_pkg::ELAP_W-1:0]       r_quo;
    logic [dcmc_pkg::CPU_W-1:0]        r_div_rem;
    logic [dcmc_pkg::CPU_W-1:0]        r_divisor;
    logic [dcmc_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [dcmc_pkg::US_SUM_W-1:0]     r_us_sum;
    logic [dcmc_pkg::MS_INC_W-1:0]     r_ms_inc;
    logic [dcmc_pkg::MS_W-1:0]         r_millis;

    logic [dcmc_pkg::COUNTER_BITS-1:0] w_diff;
    logic [dcmc_pkg::ELAP_W-1:0]       w_elapsed;
    logic [dcmc_pkg::CPU_W:0]          w_trial;
    logic                              w_ge;
    logic [dcmc_pkg::CPU_W:0]          w_trial_sub;
    logic [dcmc_pkg::US_SUM_W-1:0]     w_us_sum;
    logic [dcmc_pkg::PROD_W-1:0]       w_prod;
    logic [dcmc_pkg::US_SUM_W-1:0]     w_ms_us;
    logic [dcmc_pkg::US_SUM_W-1:0]     w_us_left;

    // Elapsed cycles since the last sample, plus the carried remainder.
    assign w_diff    = r_last - i_counter_sample;
    assign w_elapsed = {1'b0, w_diff} + dcmc_pkg::ELAP_W'(r_cyc_rem);

    // One restoring divide step: shift in the next dividend bit and try subtracting.
    assign w_trial     = {r_div_rem, r_quo[dcmc_pkg::ELAP_W-1]};
    assign w_ge        = w_trial >= {1'b0, r_divisor};
    assign w_trial_sub = w_trial - {1'b0, r_divisor};

    // Whole milliseconds in the microsecond total, by reciprocal multiply.
    assign w_us_sum = dcmc_pkg::US_SUM_W'(r_quo) + dcmc_pkg::US_SUM_W'(r_us_rem);
    assign w_prod   = dcmc_pkg::PROD_W'(w_us_sum) * dcmc_pkg::PROD_W'(dcmc_pkg::RECIP);

    // Microseconds left over after removing the whole milliseconds.
    assign w_ms_us   = dcmc_pkg::US_SUM_W'(r_ms_inc) * dcmc_pkg::US_SUM_W'(dcmc_pkg::US_PER_MS_V);
    assign w_us_left = r_us_sum - w_ms_us;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles_per_us <= dcmc_pkg::CPU_RESET;
        end else if (i_cfg_we) begin
            r_cycles_per_us <= i_cfg_wdata;
        end
    end

    // Time state and divider control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_count <= '0;
            r_us_rem   <= '0;
            r_cyc_rem  <= '0;
            r_last     <= '0;
            r_running  <= 1'b0;
            r_div_rem  <= '0;
            r_divisor  <= dcmc_pkg::CPU_W'(1);
            r_cnt      <= '0;
        end else begin
            if (i_cmd.start) begin
                r_ms_count <= '0;
                r_us_rem   <= '0;
                r_cyc_rem  <= '0;
                r_last     <= i_counter_sample;
                r_running  <= 1'b1;
            end
            if (i_cmd.load_div) begin
                r_last    <= i_counter_sample;
                r_div_rem <= '0;
                r_cnt     <= '0;
                r_divisor <= (r_cycles_per_us == '0) ? dcmc_pkg::CPU_W'(1) : r_cycles_per_us;
            end
            if (i_cmd.div_step) begin
                r_div_rem <= w_ge ? w_trial_sub[dcmc_pkg::CPU_W-1:0]
                                  : w_trial[dcmc_pkg::CPU_W-1:0];
                r_cnt     <= r_cnt + dcmc_pkg::DIV_CNT_W'(1);
            end
            if (i_cmd.mul) begin
                r_cyc_rem <= r_div_rem;
            end
            if (i_cmd.upd) begin
                r_ms_count <= r_ms_count + dcmc_pkg::MS_W'(r_ms_inc);
                r_us_rem   <= w_us_left[dcmc_pkg::US_W-1:0];
            end
        end
    end

    // Payload registers: dividend/quotient shifter, carry terms, result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quo <= w_elapsed;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[dcmc_pkg::ELAP_W-2:0], w_ge};
        end
        if (i_cmd.mul) begin
            r_us_sum <= w_us_sum;
            r_ms_inc <= w_prod[dcmc_pkg::RECIP_SHIFT +: dcmc_pkg::MS_INC_W];
        end
        if (i_cmd.out_load) begin
            r_millis <= r_ms_count;
        end
    end

    assign o_status.running  = r_running;
    assign o_status.div_last = r_cnt == dcmc_pkg::DIV_CNT_W'(dcmc_pkg::ELAP_W - 1);
    assign o_millis          = r_millis;

    // The microsecond remainder always stays below one millisecond.
    `DCMC_ASSERT_ALWAYS(a_us_range, i_clk, i_rst_n, r_us_rem < dcmc_pkg::US_PER_MS_V, "microsecond remainder out of range")
    // The working divisor is never zero.
    `DCMC_ASSERT_ALWAYS(a_divisor_nz, i_clk, i_rst_n, r_divisor != '0, "zero divisor")
    // The partial remainder stays below the divisor.
    `DCMC_ASSERT_ALWAYS(a_rem_range, i_clk, i_rst_n, r_div_rem < r_divisor, "divide remainder out of range")

endmodule

`default_nettype wire

// ----- hdl/down_counter_millisecond_clock_top.sv -----
// ============================================================================
// Millisecond clock from a down counter
// Top level: joins the controller, the datapath and the channel interfaces.
// ============================================================================
// The block keeps a wrapping 32-bit millisecond count from samples of a
// free-running 24-bit down counter. A start item while stopped clears the
// time and latches the sample; a sample item while running adds the elapsed
// cycles, divided by cycles_per_us, to the count. Every item returns one
// result with the current count. A start item, or a sample before the clock
// runs, goes straight from acceptance to hand-off. A sample while running
// passes the bit-serial divider, one cycle for each of the 25 bits of elapsed
// cycles; a reciprocal multiply and an update step then carry microseconds
// into milliseconds. A new item is accepted while a finished result waits to
// be taken. The user must write cycles_per_us through i_cfg_we and i_cfg_wdata
// only while the block is idle; the block does not enforce this. Zero acts as one.
`default_nettype none

module down_counter_millisecond_clock_top (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [dcmc_pkg::CPU_W-1:0]  i_cfg_wdata,
    dcmc_in_if.sink                    i_in,
    dcmc_out_if.source                 o_out
);

    dcmc_pkg::t_ctrl_cmd  w_cmd;
    dcmc_pkg::t_dp_status w_status;
    logic                 w_in_ready;
    logic                 w_out_valid;
    logic [dcmc_pkg::MS_W-1:0] w_millis;

    // Sequencing.
    dcmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and state.
    dcmc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_counter_sample (i_in.counter_sample),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_millis         (w_millis)
    );

    // Channel hookup.
    assign i_in.ready   = w_in_ready;
    assign o_out.valid  = w_out_valid;
    assign o_out.millis = w_millis;

endmodule

`default_nettype wire
